// ----- rtl/core/led_matrix_chain_shadow_driver_defines.svh -----
// Assertion macros for the LED matrix chain shadow driver.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef LED_MATRIX_CHAIN_SHADOW_DRIVER_DEFINES_SVH
`define LED_MATRIX_CHAIN_SHADOW_DRIVER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define LMCSD_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("lmcsd check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define LMCSD_ASSERT_NXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("lmcsd check failed");
`else
`define LMCSD_ASSERT_IMP(label, lhs, rhs)
`define LMCSD_ASSERT_NXT(label, lhs, rhs)
`endif
`endif

// ----- rtl/core/lmcsd_pkg.sv -----
// Shared constants for the LED matrix chain shadow driver.
// Depends on nothing.
package lmcsd_pkg;

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_ROW   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam int         ROWS_PER_DEV = 8;
    localparam logic [7:0] COL0_MASK    = 8'd128;
    localparam logic [7:0] BLANK        = 8'h00;

endpackage

// ----- rtl/core/led_matrix_chain_shadow_driver.sv -----
// Usage: a request on the input channel (in_valid, in_stall) carries one command: set or
// clear a pixel, write a whole row, or clear a device. The block keeps a shadow of eight
// row bytes per chip and answers each command with a burst of serial bytes on the output
// channel (out_valid, out_stall). A pixel or row command yields one chain frame of
// 2*NUM_DEVICES bytes, highest device first; a clear yields sixteen bytes, eight frames.
// frame_end asks for the load strobe after its byte, and last marks the final byte.
// Commands with a device at or above NUM_DEVICES, or with an unused code, are dropped.
// A row write or a clear goes from idle straight to the emit state, which loads each byte
// into the output register once the output register is free; a pixel command first passes
// the read state (memory read) and the modify state (modify and write back). Further bytes
// follow without a gap when the receiver does not stall.
// Only one command is in flight: in_stall is high until the last byte has been loaded into
// the output register, so the next request can be taken while that byte still waits.
// When the receiver stalls, the output byte holds and the sequencer waits with it.
// Reset clears the control state and the per-entry valid bits, so the shadow reads as all
// zeros at once; no clearing pass is needed.
`include "led_matrix_chain_shadow_driver_defines.svh"

module led_matrix_chain_shadow_driver
    import lmcsd_pkg::*;
#(
    parameter int NUM_DEVICES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [2:0] device,
    input  logic [2:0] row,
    input  logic [2:0] column,
    input  logic       pixel_on,
    input  logic [7:0] row_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] serial_byte,
    output logic       frame_end,
    output logic       last
);

    localparam int         DEPTH      = NUM_DEVICES * ROWS_PER_DEV;
    localparam int         ADDR_W     = $clog2(DEPTH);
    localparam logic [3:0] DEV_LIMIT  = 4'(NUM_DEVICES);
    localparam logic [2:0] TOP_SLOT   = 3'(NUM_DEVICES - 1);
    localparam logic [3:0] CHAIN_LAST = 4'(2 * NUM_DEVICES - 1);
    localparam logic [3:0] CLEAR_LAST = 4'(2 * ROWS_PER_DEV - 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_MODIFY, S_EMIT} state_t;

    // Control and output registers.
    state_t      state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        fend_reg, fend_next;
    logic        last_reg, last_next;

    // Command context, held while the command is worked on.
    logic              is_clear_reg, is_clear_next;
    logic [2:0]        hit_slot_reg, hit_slot_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic [7:0]        data_reg, data_next;
    logic [2:0]        column_reg, column_next;
    logic              pixel_on_reg, pixel_on_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    // Shadow memory with one valid bit per entry; an invalid entry reads as zero.
    logic [7:0]  mem_array [DEPTH];
    logic [7:0]  rd_data_reg;
    logic        rd_valid_reg;
    logic        valid_reg [DEPTH];

    logic              in_acc;
    logic              cmd_ok;
    logic              dev_ok;
    logic [ADDR_W-1:0] in_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr_en;
    logic              slot_free;
    logic              out_acc;
    logic [7:0]        mask;
    logic [7:0]        cur_row;
    logic [7:0]        new_row;
    logic              hit;
    logic [7:0]        gen_byte;
    logic              gen_fend;
    logic              gen_last;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign cmd_ok      = (cmd == CMD_PIXEL) || (cmd == CMD_ROW) || (cmd == CMD_CLEAR);
    assign dev_ok      = ({1'b0, device} < DEV_LIMIT);
    assign in_addr     = ADDR_W'({device, row});
    assign out_acc     = out_valid_reg && !out_stall;
    assign slot_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign serial_byte = byte_reg;
    assign frame_end   = fend_reg;
    assign last        = last_reg;

    // Read-modify-write of one pixel: the row arrives in the cycle after the read.
    assign mask    = COL0_MASK >> column_reg;
    assign cur_row = rd_valid_reg ? rd_data_reg : BLANK;
    assign new_row = pixel_on_reg ? (cur_row | mask) : (cur_row & ~mask);

    // Write port: a row write goes in at acceptance, a pixel update in the modify cycle.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = in_addr;
        wr_data = row_value;
        if (state_reg == S_MODIFY)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = new_row;
        end
        else if (in_acc && dev_ok && (cmd == CMD_ROW))
        begin
            wr_en = 1'b1;
        end
    end

    assign clr_en = in_acc && dev_ok && (cmd == CMD_CLEAR);

    // Byte of the current burst, chosen by the byte counter.
    always_comb
    begin
        hit = (cnt_reg[3:1] == hit_slot_reg);
        if (is_clear_reg)
        begin
            gen_byte = cnt_reg[0] ? BLANK : {5'd0, cnt_reg[3:1]} + 8'd1;
            gen_fend = cnt_reg[0];
            gen_last = (cnt_reg == CLEAR_LAST);
        end
        else
        begin
            if (!hit)
                gen_byte = BLANK;
            else if (cnt_reg[0])
                gen_byte = data_reg;
            else
                gen_byte = {4'd0, opcode_reg};
            gen_fend = cnt_reg[0] && (cnt_reg[3:1] == TOP_SLOT);
            gen_last = (cnt_reg == CHAIN_LAST);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        fend_next      = fend_reg;
        last_next      = last_reg;
        is_clear_next  = is_clear_reg;
        hit_slot_next  = hit_slot_reg;
        opcode_next    = opcode_reg;
        data_next      = data_reg;
        column_next    = column_reg;
        pixel_on_next  = pixel_on_reg;
        addr_next      = addr_reg;

        if (out_acc)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && dev_ok && cmd_ok)
                begin
                    cnt_next      = 4'd0;
                    is_clear_next = (cmd == CMD_CLEAR);
                    hit_slot_next = TOP_SLOT - device;
                    opcode_next   = {1'b0, row} + 4'd1;
                    data_next     = row_value;
                    column_next   = column;
                    pixel_on_next = pixel_on;
                    addr_next     = in_addr;
                    state_next    = (cmd == CMD_PIXEL) ? S_READ : S_EMIT;
                end
            end
            S_READ:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                data_next  = new_row;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = gen_byte;
                    fend_next      = gen_fend;
                    last_next      = gen_last;
                    cnt_next       = cnt_reg + 4'd1;
                    if (gen_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        fend_reg     <= fend_next;
        last_reg     <= last_next;
        is_clear_reg <= is_clear_next;
        hit_slot_reg <= hit_slot_next;
        opcode_reg   <= opcode_next;
        data_reg     <= data_next;
        column_reg   <= column_next;
        pixel_on_reg <= pixel_on_next;
        addr_reg     <= addr_next;
    end

    // Shadow memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_array[wr_addr] <= wr_data;
        rd_data_reg <= mem_array[addr_reg];
    end

    // Valid bits: a write sets its entry, a device clear drops that device's eight rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                valid_reg[i] <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (clr_en && ((ADDR_W'(i) >> 3) == ADDR_W'(device)))
                    valid_reg[i] <= 1'b0;
                else if (wr_en && (wr_addr == ADDR_W'(i)))
                    valid_reg[i] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[addr_reg];
        end
    end

    // The final byte of every command always closes a frame.
    `LMCSD_ASSERT_IMP(a_last_ends_frame, out_valid && last, frame_end)
    // Within a burst, a taken byte is replaced by the next one without a gap.
    `LMCSD_ASSERT_NXT(a_burst_no_gap, out_valid && !out_stall && !last, out_valid)
    // A stalled output byte stays offered and does not change.
    `LMCSD_ASSERT_NXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(serial_byte))

endmodule
